>>> rtl/audio_dc_block_dither_quantizer_top_assert.svh
// Assertion macros for the top level RTL of the DC blocker and quantizer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef AUDIO_DC_BLOCK_DITHER_QUANTIZER_TOP_ASSERT_SVH
`define AUDIO_DC_BLOCK_DITHER_QUANTIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADBDQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adbdq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADBDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adbdq assertion failed");

// The consequent must hold in the cycle after reset is applied.
`define ADBDQ_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("adbdq reset assertion failed");

`endif

>>> rtl/adbdq_pkg.sv
package adbdq_pkg;

  localparam int STEP_W = 4;

  localparam int PRESCALE_W = 16;
  localparam int DC_RATE_W  = 24;
  localparam int OUT_GAIN_W = 15;
  localparam int IN_W       = 18;
  localparam int OUT_W      = 16;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd52429;
  localparam logic [DC_RATE_W-1:0]  DC_RATE_RESET  = 24'd8389;
  localparam logic [OUT_GAIN_W-1:0] OUT_GAIN_RESET = 15'd28672;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PRESCALE = 2'd0;
  localparam logic [1:0] REG_DC_RATE  = 2'd1;
  localparam logic [1:0] REG_OUT_GAIN = 2'd2;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_MUL_XP,
    OP_LOAD_A,
    OP_DIFF,
    OP_MUL_DLO,
    OP_MUL_DHI,
    OP_ACC_HI,
    OP_DC_UPD,
    OP_CLIP,
    OP_MUL_BLO,
    OP_MUL_BHI,
    OP_DITHER,
    OP_SUB_DC,
    OP_QUANT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEVER,
    JMP_NO_INPUT,
    JMP_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] target;
    logic             done;
  } ctrl_word_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_QUANT = 4'd14;

  // Microprogram for one sample.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w.op     = OP_WAIT;
    w.cond   = JMP_NEVER;
    w.target = STEP_WAIT;
    w.done   = 1'b0;
    unique case (step)
      4'd0: begin
        w.op     = OP_WAIT;
        w.cond   = JMP_NO_INPUT;
        w.target = STEP_WAIT;
      end
      4'd1:  w.op = OP_MUL_XP;
      4'd2:  w.op = OP_LOAD_A;
      4'd3:  w.op = OP_DIFF;
      4'd4:  w.op = OP_MUL_DLO;
      4'd5:  w.op = OP_MUL_DHI;
      4'd6:  w.op = OP_ACC_HI;
      4'd7:  w.op = OP_DC_UPD;
      4'd8:  w.op = OP_CLIP;
      4'd9:  w.op = OP_MUL_BLO;
      4'd10: w.op = OP_MUL_BHI;
      4'd11: w.op = OP_ACC_HI;
      4'd12: w.op = OP_DITHER;
      4'd13: w.op = OP_SUB_DC;
      4'd14: begin
        w.op     = OP_QUANT;
        w.cond   = JMP_OUT_BUSY;
        w.target = STEP_QUANT;
        w.done   = 1'b1;
      end
      default: begin
        w.op   = OP_WAIT;
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/audio_dc_block_dither_quantizer_top.sv
// DC blocker with triangular dither and 16-bit quantizer. Each transaction on
// the input channel carries one signed Q1.16 sample; the block scales it by
// prescale, moves its DC estimate toward the scaled sample by dc_rate, clips
// the DC-free sample to plus or minus one, applies out_gain, adds triangular
// dither from two xorshift draws, removes the DC estimate once more and
// truncates toward zero to a saturated 16-bit sample, which leaves on the
// output channel as one transaction. The result is loaded into the output
// register at the last step of the microprogram; the steps after the wait
// step drive a single shared 22 by 25 bit multiplier through five products.
// The next sample is accepted in the cycle after its predecessor's result is
// loaded into the output register, so the block takes no new sample before
// it is through with the last one, and a result still held by a stalled
// output only delays that load. The three registers sit on the APB port at
// byte addresses 0 (prescale), 4 (dc_rate) and 8 (out_gain), and should be
// written only while no sample is in flight.
module audio_dc_block_dither_quantizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adbdq_pkg::PADDR_W-1:0]       paddr,
  input  logic [adbdq_pkg::PDATA_W-1:0]       pwdata,
  output logic [adbdq_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [adbdq_pkg::IN_W-1:0]   in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adbdq_pkg::OUT_W-1:0]  out_sample
);
  import adbdq_pkg::*;

  `include "audio_dc_block_dither_quantizer_top_assert.svh"

  logic [PRESCALE_W-1:0] prescale;
  logic [DC_RATE_W-1:0]  dc_rate;
  logic [OUT_GAIN_W-1:0] out_gain;
  logic                  cfg_write;
  dp_ctrl_t              ctrl;
  dp_status_t            status;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes; an address beyond the three registers is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= PRESCALE_RESET;
      dc_rate  <= DC_RATE_RESET;
      out_gain <= OUT_GAIN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_PRESCALE: prescale <= pwdata[PRESCALE_W-1:0];
        REG_DC_RATE:  dc_rate  <= pwdata[DC_RATE_W-1:0];
        REG_OUT_GAIN: out_gain <= pwdata[OUT_GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads return the value zero extended to the bus width.
  always_comb begin
    unique case (paddr[3:2])
      REG_PRESCALE: prdata = PDATA_W'(prescale);
      REG_DC_RATE:  prdata = PDATA_W'(dc_rate);
      REG_OUT_GAIN: prdata = PDATA_W'(out_gain);
      default:      prdata = '0;
    endcase
  end

  // The sequencer steps through the microprogram and holds at the wait step
  // until a sample arrives, and at the last step while a stalled output is full.
  adbdq_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // The datapath holds the sample, the DC estimate, the noise generator, the
  // shared multiplier, the accumulator and the output register.
  adbdq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_sample  (in_sample),
    .prescale   (prescale),
    .dc_rate    (dc_rate),
    .out_gain   (out_gain),
    .out_sample (out_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  // Once a sample is taken, no further sample is taken until its result is out.
  `ADBDQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A new result appears exactly as the sequencer returns to its wait step.
  `ADBDQ_ASSERT_SAME(a_result_with_wait, $rose(out_valid), !in_stall)
  // Reset leaves the output empty and the sequencer ready for a sample.
  `ADBDQ_ASSERT_RESET(a_reset_state, !out_valid && !in_stall)

endmodule

>>> rtl/adbdq_sequencer.sv
module adbdq_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  adbdq_pkg::dp_status_t status,
  output adbdq_pkg::dp_ctrl_t   ctrl,
  output logic                  in_stall
);
  import adbdq_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_word_t        cw;
  logic              jump;

  assign cw = ucode(step);

  always_comb begin
    unique case (cw.cond)
      JMP_NO_INPUT: jump = !in_valid;
      JMP_OUT_BUSY: jump = status.out_busy;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_next = cw.target;
    end else if (cw.done) begin
      step_next = STEP_WAIT;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // Only the wait step takes input.
  assign in_stall  = (cw.cond != JMP_NO_INPUT);
  assign ctrl.op   = cw.op;
  assign ctrl.fire = !jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/adbdq_datapath.sv
module adbdq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  adbdq_pkg::dp_ctrl_t                 ctrl,
  output adbdq_pkg::dp_status_t               status,
  input  logic signed [adbdq_pkg::IN_W-1:0]   in_sample,
  input  logic [adbdq_pkg::PRESCALE_W-1:0]    prescale,
  input  logic [adbdq_pkg::DC_RATE_W-1:0]     dc_rate,
  input  logic [adbdq_pkg::OUT_GAIN_W-1:0]    out_gain,
  output logic signed [adbdq_pkg::OUT_W-1:0]  out_sample,
  output logic                                out_valid,
  input  logic                                out_stall
);
  import adbdq_pkg::*;

  localparam logic signed [40:0] ONE_41 = 41'sd4294967296;
  localparam logic signed [33:0] ONE_34 = 34'sd4294967296;
  localparam logic signed [65:0] ONE_66 = 66'sd4294967296;
  localparam logic signed [33:0] Q_MAX  = 34'sd32767;
  localparam logic signed [33:0] Q_MIN  = -34'sd32768;

  logic signed [17:0] x;
  logic signed [34:0] a;
  logic signed [39:0] dc_level;
  logic signed [40:0] diff;
  logic signed [33:0] b;
  logic signed [46:0] prod;
  logic signed [65:0] acc;
  logic [63:0]        noise_state;
  logic [22:0]        m1;
  logic [22:0]        m2;

  logic signed [21:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [46:0] mul_p;
  logic [63:0]        draw;
  logic signed [40:0] a_minus_dc;
  logic signed [33:0] clip;
  logic signed [33:0] q_floor;
  logic signed [33:0] q_trunc;
  logic signed [OUT_W-1:0] q_sat;
  logic [23:0]        mant_sum;

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

  assign draw = xorshift(noise_state);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl.op)
      OP_MUL_XP: begin
        mul_a = 22'(x);
        mul_b = $signed({9'd0, prescale});
      end
      OP_MUL_DLO: begin
        mul_a = $signed({2'd0, diff[19:0]});
        mul_b = $signed({1'b0, dc_rate});
      end
      OP_MUL_DHI: begin
        mul_a = $signed({diff[40], diff[40:20]});
        mul_b = $signed({1'b0, dc_rate});
      end
      OP_MUL_BLO: begin
        mul_a = $signed({2'd0, b[19:0]});
        mul_b = $signed({10'd0, out_gain});
      end
      OP_MUL_BHI: begin
        mul_a = 22'($signed(b[33:20]));
        mul_b = $signed({10'd0, out_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign a_minus_dc = 41'(a) - 41'(dc_level);

  always_comb begin
    if (a_minus_dc > ONE_41) begin
      clip = ONE_34;
    end else if (a_minus_dc < -ONE_41) begin
      clip = -ONE_34;
    end else begin
      clip = a_minus_dc[33:0];
    end
  end

  assign mant_sum = {1'b0, m1} + {1'b0, m2};

  // Truncation toward zero: floor, then step up for a negative value with a fraction.
  assign q_floor = acc[65:32];
  assign q_trunc = q_floor + 34'($unsigned(acc[65] && (acc[31:0] != 32'd0)));

  always_comb begin
    if (q_trunc > Q_MAX) begin
      q_sat = 16'sh7FFF;
    end else if (q_trunc < Q_MIN) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q_trunc[15:0];
    end
  end

  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      unique case (ctrl.op)
        OP_WAIT:    x <= in_sample;
        OP_MUL_XP:  prod <= mul_p;
        OP_LOAD_A:  a <= prod[34:0];
        OP_DIFF:    diff <= a_minus_dc;
        OP_MUL_DLO: prod <= mul_p;
        OP_MUL_DHI: begin
          prod <= mul_p;
          acc  <= 66'(prod);
        end
        OP_ACC_HI:  acc <= acc + (66'(prod) <<< 20);
        OP_CLIP:    b <= clip;
        OP_MUL_BLO: prod <= mul_p;
        OP_MUL_BHI: begin
          prod <= mul_p;
          acc  <= 66'(prod);
        end
        OP_DITHER:  acc <= acc + $signed({33'd0, mant_sum, 9'd0}) - ONE_66;
        OP_SUB_DC:  acc <= acc - 66'(dc_level);
        OP_QUANT:   out_sample <= q_sat;
        default: begin
        end
      endcase
    end
  end

  // State and handshake registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_level    <= '0;
      noise_state <= 64'd1;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.fire && (ctrl.op == OP_DC_UPD)) begin
        dc_level <= dc_level + acc[63:24];
      end
      if (ctrl.fire && ((ctrl.op == OP_MUL_XP) || (ctrl.op == OP_LOAD_A))) begin
        noise_state <= draw;
      end
      if (ctrl.fire && (ctrl.op == OP_QUANT)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && (ctrl.op == OP_MUL_XP)) begin
      m1 <= draw[22:0];
    end
    if (ctrl.fire && (ctrl.op == OP_LOAD_A)) begin
      m2 <= draw[22:0];
    end
  end

endmodule
